// ===== sv/wbps_pkg.sv =====
// Shared constants, types and helpers of the wildcard byte pattern scanner.
package wbps_pkg;

  localparam int MAX_PATTERN_BYTES = 32;
  localparam int BYTE_W            = 8;
  localparam int LEN_W             = 6;
  localparam int SHIFT_W           = $clog2(MAX_PATTERN_BYTES);
  localparam int PATTERN_W         = MAX_PATTERN_BYTES * BYTE_W;
  localparam int ADDR_W            = 32;
  localparam int CFG_DATA_W        = 64;
  localparam int CFG_IDX_W         = 3;
  localparam int QUEUE_DEPTH       = 2;
  localparam int QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH = 3'd0,
    CFG_PATTERN_WORD_0 = 3'd1,
    CFG_PATTERN_WORD_1 = 3'd2,
    CFG_PATTERN_WORD_2 = 3'd3,
    CFG_PATTERN_WORD_3 = 3'd4,
    CFG_WILDCARD_MASK  = 3'd5,
    CFG_REGION_BASE    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [LEN_W-1:0]             pattern_length;
    logic [PATTERN_W-1:0]         pattern;
    logic [MAX_PATTERN_BYTES-1:0] wildcard_mask;
    logic [ADDR_W-1:0]            region_base;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_region;
  } q_entry_t;

  // Number of pattern bytes actually compared: zero acts as one, and the
  // length is capped at the widest supported pattern.
  function automatic logic [LEN_W-1:0] length_in_use(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    n = len;
    if (n == '0) begin
      n = LEN_W'(1);
    end
    if (n > LEN_W'(MAX_PATTERN_BYTES)) begin
      n = LEN_W'(MAX_PATTERN_BYTES);
    end
    return n;
  endfunction

endpackage

// ===== sv/wbps_if.sv =====
// Valid/ready channel interfaces for the scanner's byte input and result output.
interface wbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_region;

  modport source (output valid, output data_byte, output end_of_region, input ready);
  modport sink (input valid, input data_byte, input end_of_region, output ready);
endinterface

interface wbps_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_address;

  modport source (output valid, output found, output match_address, input ready);
  modport sink (input valid, input found, input match_address, output ready);
endinterface

// ===== sv/wbps_cfg.sv =====
// Configuration register file of the scanner.
module wbps_cfg
  import wbps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PATTERN_LENGTH: cfg_nxt.pattern_length = cfg_wr_data[LEN_W-1:0];
        CFG_PATTERN_WORD_0: cfg_nxt.pattern[0*CFG_DATA_W +: CFG_DATA_W] = cfg_wr_data;
        CFG_PATTERN_WORD_1: cfg_nxt.pattern[1*CFG_DATA_W +: CFG_DATA_W] = cfg_wr_data;
        CFG_PATTERN_WORD_2: cfg_nxt.pattern[2*CFG_DATA_W +: CFG_DATA_W] = cfg_wr_data;
        CFG_PATTERN_WORD_3: cfg_nxt.pattern[3*CFG_DATA_W +: CFG_DATA_W] = cfg_wr_data;
        CFG_WILDCARD_MASK:  cfg_nxt.wildcard_mask = cfg_wr_data[MAX_PATTERN_BYTES-1:0];
        CFG_REGION_BASE:    cfg_nxt.region_base = cfg_wr_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_length <= LEN_W'(1);
      cfg_r.pattern        <= '0;
      cfg_r.wildcard_mask  <= '0;
      cfg_r.region_base    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/wbps_queue.sv =====
// Front end: accepts byte requests and holds them in a two-entry queue.
module wbps_queue
  import wbps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  wbps_in_if.sink   in_ch,
  output logic      q_valid,
  output q_entry_t  q_entry,
  input  logic      q_pop
);

  q_entry_t               mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;
  logic                   push;

  assign in_ch.ready = (count_r != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != '0);
  assign q_entry     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QUEUE_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + QUEUE_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + QUEUE_CNT_W'(1);
    end else if (!push && q_pop) begin
      count_nxt = count_r - QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{data_byte: in_ch.data_byte, end_of_region: in_ch.end_of_region};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== sv/wbps_back.sv =====
// Back end: sliding byte window, masked pattern compare and result register.
module wbps_back
  import wbps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  q_entry_t   q_entry,
  output logic       q_pop,
  wbps_out_if.source out_ch
);

  logic [BYTE_W-1:0]            window_r [MAX_PATTERN_BYTES];
  logic [BYTE_W-1:0]            win_shift [MAX_PATTERN_BYTES];
  logic [LEN_W-1:0]             seen_r, seen_nxt, seen_inc;
  logic [ADDR_W-1:0]            offset_r, offset_nxt;
  logic                         reported_r, reported_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_found_r;
  logic [ADDR_W-1:0]            out_addr_r;

  logic [LEN_W-1:0]             n;
  logic [SHIFT_W-1:0]           sh;
  logic [PATTERN_W-1:0]         rpat, apat;
  logic [MAX_PATTERN_BYTES-1:0] rwild, awild, len_mask, care, hit;
  logic                         match;
  logic                         res_load, res_found;
  logic [ADDR_W-1:0]            res_addr;

  // Pattern byte i lines up with window entry n-1-i: reverse the pattern and
  // shift it down so that aligned entry j compares against window entry j.
  always_comb begin
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      rpat[k*BYTE_W +: BYTE_W] = cfg.pattern[(MAX_PATTERN_BYTES-1-k)*BYTE_W +: BYTE_W];
      rwild[k]                 = cfg.wildcard_mask[MAX_PATTERN_BYTES-1-k];
    end
  end

  assign n        = length_in_use(cfg.pattern_length);
  assign sh       = SHIFT_W'(LEN_W'(MAX_PATTERN_BYTES) - n);
  assign apat     = rpat >> {sh, 3'b000};
  assign awild    = rwild >> sh;
  assign len_mask = ~({MAX_PATTERN_BYTES{1'b1}} << n);
  assign care     = len_mask & ~awild;

  always_comb begin
    win_shift[0] = q_entry.data_byte;
    for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
      win_shift[k] = window_r[k-1];
    end
    for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
      hit[j] = !care[j] || (win_shift[j] == apat[j*BYTE_W +: BYTE_W]);
    end
  end

  assign seen_inc = (seen_r < LEN_W'(MAX_PATTERN_BYTES)) ? seen_r + LEN_W'(1) : seen_r;
  assign match    = (seen_inc >= n) && (&hit);
  assign q_pop    = q_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    seen_nxt     = seen_r;
    offset_nxt   = offset_r;
    reported_nxt = reported_r;
    res_load     = 1'b0;
    res_found    = 1'b0;
    res_addr     = '0;
    if (q_pop) begin
      if (!reported_r) begin
        seen_nxt   = seen_inc;
        offset_nxt = offset_r + ADDR_W'(1);
        if (match) begin
          res_load     = 1'b1;
          res_found    = 1'b1;
          res_addr     = cfg.region_base + offset_r - ADDR_W'(n) + ADDR_W'(1);
          reported_nxt = 1'b1;
        end else if (q_entry.end_of_region) begin
          res_load = 1'b1;
        end
      end
      if (q_entry.end_of_region) begin
        seen_nxt     = '0;
        offset_nxt   = '0;
        reported_nxt = 1'b0;
      end
    end
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && !reported_r) begin
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
        window_r[k] <= win_shift[k];
      end
    end
    if (res_load) begin
      out_found_r <= res_found;
      out_addr_r  <= res_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      offset_r    <= '0;
      reported_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seen_r      <= seen_nxt;
      offset_r    <= offset_nxt;
      reported_r  <= reported_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.found         = out_found_r;
  assign out_ch.match_address = out_addr_r;

endmodule

// ===== sv/wildcard_byte_pattern_scan_core.sv =====
// Top level of the wildcard byte pattern scanner.
//
//   channel  direction  payload                         handshake
//   in_ch    input      data_byte, end_of_region        valid / ready
//   out_ch   output     found, match_address            valid / ready
//   cfg_*    input      cfg_index, cfg_wr_data          cfg_wr_en, no wait
//
// One byte request is taken per cycle while the queue has room; a taken byte
// is written into the queue, and its compare result, if any, is registered
// for out_ch. A two-entry queue separates the input from the compare unit,
// which stalls only while the output register holds a result not yet taken.
// Reset is synchronous and active low and clears all control state.
module wildcard_byte_pattern_scan_core
  import wbps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  wbps_in_if.sink               in_ch,
  wbps_out_if.source            out_ch,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  cfg_t     cfg;
  logic     q_valid;
  q_entry_t q_entry;
  logic     q_pop;

  wbps_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  wbps_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop)
  );

  wbps_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // A not-found result always carries a zero address.
  a_notfound_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.found) |-> (out_ch.match_address == '0))
    else $error("not-found result with nonzero address");

  // The compare unit drains the queue whenever the output register has room.
  a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && (!out_ch.valid || out_ch.ready)) |-> q_pop)
    else $error("queued byte not taken although output is free");

  // A result appears only after a byte has left the queue.
  a_result_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(q_pop))
    else $error("result without a processed byte");

endmodule
